>>> sv/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types for the sorted leaderboard
// Entry layout, cell control word, cell operations and sequencer states.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int NAME_LO_W = 64;
  localparam int NAME_HI_W = 8;
  localparam int SCORE_W   = 32;
  localparam int RANK_W    = 5;

  typedef struct packed {
    logic [NAME_LO_W-1:0] name_lo;
    logic [NAME_HI_W-1:0] name_hi;
    logic [SCORE_W-1:0]   score;
  } slr_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_ROTATE
  } slr_op_t;

  typedef struct packed {
    slr_op_t op;
    logic    valid;  // cell holds a live entry
    logic    shift;  // a matching name sits at or above this cell
  } slr_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_EMIT
  } slr_state_t;

endpackage

>>> sv/slr_in_if.sv
// ----------------------------------------------------------------------------
// slr_in_if: update channel
// Carries one player name and score per beat.
// ----------------------------------------------------------------------------
interface slr_in_if;
  logic                              valid;
  logic                              ready;
  logic [slr_pkg::NAME_LO_W-1:0]     name_low;
  logic [slr_pkg::NAME_HI_W-1:0]     name_high;
  logic signed [slr_pkg::SCORE_W-1:0] score_in;

  modport source (output valid, output name_low, output name_high, output score_in,
                  input ready);
  modport sink   (input valid, input name_low, input name_high, input score_in,
                  output ready);
endinterface

>>> sv/slr_out_if.sv
// ----------------------------------------------------------------------------
// slr_out_if: ranked entry channel
// Carries one table entry per beat, in rank order.
// ----------------------------------------------------------------------------
interface slr_out_if;
  logic                               valid;
  logic                               ready;
  logic [slr_pkg::RANK_W-1:0]         rank;
  logic [slr_pkg::NAME_LO_W-1:0]      entry_name_low;
  logic [slr_pkg::NAME_HI_W-1:0]      entry_name_high;
  logic signed [slr_pkg::SCORE_W-1:0] entry_score;
  logic                               last_entry;

  modport source (output valid, output rank, output entry_name_low,
                  output entry_name_high, output entry_score, output last_entry,
                  input ready);
  modport sink   (input valid, input rank, input entry_name_low,
                  input entry_name_high, input entry_score, input last_entry,
                  output ready);
endinterface

>>> sv/slr_cell.sv
// ----------------------------------------------------------------------------
// slr_cell: one slot of the leaderboard chain
// Holds one entry; on command takes its own, a neighbor's or the new entry.
// ----------------------------------------------------------------------------
module slr_cell (
  input  logic                   clk,
  input  slr_pkg::slr_cell_ctl_t ctl,
  input  slr_pkg::slr_entry_t    new_entry,
  input  slr_pkg::slr_entry_t    prev_entry,
  input  slr_pkg::slr_entry_t    next_entry,
  input  logic                   below_prev,
  output logic                   below_o,
  output logic                   match_o,
  output slr_pkg::slr_entry_t    entry_o
);

  slr_pkg::slr_entry_t entry_r;
  slr_pkg::slr_entry_t entry_nxt;

  // Empty cells count as lower than anything, so the new entry lands at the tail.
  assign below_o = !ctl.valid || ($signed(entry_r.score) < $signed(new_entry.score));
  assign match_o = ctl.valid && (entry_r.name_lo == new_entry.name_lo)
                             && (entry_r.name_hi == new_entry.name_hi);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      slr_pkg::OP_HOLD: begin
        entry_nxt = entry_r;
      end
      slr_pkg::OP_REMOVE: begin
        if (ctl.shift) begin
          entry_nxt = next_entry;
        end
      end
      slr_pkg::OP_INSERT: begin
        if (below_prev) begin
          entry_nxt = prev_entry;
        end else if (below_o) begin
          entry_nxt = new_entry;
        end
      end
      slr_pkg::OP_ROTATE: begin
        entry_nxt = next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> sv/sorted_leaderboard_update.sv
// ----------------------------------------------------------------------------
// sorted_leaderboard_update: ranked table of players by descending score
// Same-name replace, stable insert after ties, full-table drop, full dump.
// ----------------------------------------------------------------------------
// The table lives in a ring of CAPACITY cells, cell 0 holding rank 1. Each
// update beat runs through these steps: latch and normalize the name, close
// the gap left by a same-name entry, open a gap and drop the new entry in,
// then rotate the ring one cell per cycle so that every cell passes cell 0,
// the read point of the result channel. Only the first entry_count of those
// rotate steps carry result beats; a stalled result beat holds the ring.
// The input is ready only between updates. A name ends at its first zero
// character; later characters are cleared before compare and store. Scores
// are signed Q16.16; a new entry goes after existing equal scores. When the
// table is full the lowest entry falls off the end, or the new entry is
// discarded if it would rank last.
// ----------------------------------------------------------------------------
module sorted_leaderboard_update #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst_n,
  slr_in_if.sink    in_ch,
  slr_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Clear every character after the first zero one.
  function automatic slr_pkg::slr_entry_t normalize_entry(
    input logic [slr_pkg::NAME_LO_W-1:0] lo,
    input logic [slr_pkg::NAME_HI_W-1:0] hi,
    input logic [slr_pkg::SCORE_W-1:0]   sc
  );
    slr_pkg::slr_entry_t e;
    logic                ended;
    e.name_lo = lo;
    e.name_hi = hi;
    e.score   = sc;
    ended     = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (ended) begin
        e.name_lo[8*b +: 8] = 8'd0;
      end else if (lo[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    if (ended) begin
      e.name_hi = '0;
    end
    return e;
  endfunction

  slr_pkg::slr_state_t  state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  slr_pkg::slr_entry_t  new_r;

  slr_pkg::slr_op_t     op_w;
  logic                 advance;
  logic                 in_fire;
  logic [CNT_W-1:0]     k_ext;

  slr_pkg::slr_entry_t  entry_w  [CAPACITY];
  logic [CAPACITY-1:0]  below_vec;
  logic [CAPACITY-1:0]  match_vec;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign k_ext   = CNT_W'(k_r);

  // Skip rotate cycles past the live entries without waiting on the sink.
  assign advance = (k_ext >= count_r) || out_ch.ready;

  // ---- sequencer: next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = slr_pkg::ST_REMOVE;
        end
      end
      slr_pkg::ST_REMOVE: begin
        state_nxt = slr_pkg::ST_INSERT;
      end
      slr_pkg::ST_INSERT: begin
        state_nxt = slr_pkg::ST_EMIT;
      end
      slr_pkg::ST_EMIT: begin
        if (advance && (k_r == IDX_W'(CAPACITY - 1))) begin
          state_nxt = slr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slr_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    op_w         = slr_pkg::OP_HOLD;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      slr_pkg::ST_REMOVE: begin
        op_w = slr_pkg::OP_REMOVE;
      end
      slr_pkg::ST_INSERT: begin
        op_w = slr_pkg::OP_INSERT;
      end
      slr_pkg::ST_EMIT: begin
        out_ch.valid = (k_ext < count_r);
        op_w         = advance ? slr_pkg::OP_ROTATE : slr_pkg::OP_HOLD;
      end
      default: begin
        op_w = slr_pkg::OP_HOLD;
      end
    endcase
  end

  // ---- entry count and dump index ----
  always_comb begin
    count_nxt = count_r;
    k_nxt     = k_r;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        k_nxt = '0;
      end
      slr_pkg::ST_REMOVE: begin
        // Drop one entry when the name is already on the board.
        if (|match_vec) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      slr_pkg::ST_INSERT: begin
        // A full board stays full: either the tail or the new entry drops.
        if (count_r != CNT_W'(CAPACITY)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        k_nxt = '0;
      end
      slr_pkg::ST_EMIT: begin
        if (advance) begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      default: begin
        k_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slr_pkg::ST_IDLE;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
  end

  // Hold the normalized update for the compare and insert cycles.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      new_r <= normalize_entry(in_ch.name_low, in_ch.name_high, in_ch.score_in);
    end
  end

  // ---- cell ring ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slr_pkg::slr_cell_ctl_t ctl;
    logic                   below_prev;
    slr_pkg::slr_entry_t    prev_entry;

    if (i == 0) begin : g_head
      assign below_prev = 1'b0;
      assign prev_entry = new_r;
    end else begin : g_body
      assign below_prev = below_vec[i-1];
      assign prev_entry = entry_w[i-1];
    end

    assign ctl.op    = op_w;
    assign ctl.valid = (CNT_W'(i) < count_r);
    // Close the gap: every cell at or below the matching one pulls up.
    assign ctl.shift = |match_vec[i:0];

    slr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_r),
      .prev_entry (prev_entry),
      .next_entry (entry_w[(i + 1) % CAPACITY]),
      .below_prev (below_prev),
      .below_o    (below_vec[i]),
      .match_o    (match_vec[i]),
      .entry_o    (entry_w[i])
    );
  end

  // ---- result beat: read at the ring head ----
  assign out_ch.rank            = slr_pkg::RANK_W'(k_ext + CNT_W'(1));
  assign out_ch.entry_name_low  = entry_w[0].name_lo;
  assign out_ch.entry_name_high = entry_w[0].name_hi;
  assign out_ch.entry_score     = entry_w[0].score;
  assign out_ch.last_entry      = ((k_ext + CNT_W'(1)) == count_r);

endmodule

>>> sv/slr_checker.sv
// ----------------------------------------------------------------------------
// slr_checker: port-level checks for the sorted leaderboard
// Watches the update and result channels and their ordering over time.
// ----------------------------------------------------------------------------
module slr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [slr_pkg::RANK_W-1:0] out_rank,
  input logic                       out_last
);

  // Never take an update while a dump is in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("update ready while result beat pending");

  // One update at a time.
  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second update taken back to back");

  // Ranks count up by one within a dump.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_rank == slr_pkg::RANK_W'($past(out_rank) + 1'b1))))
    else $error("rank did not advance by one");

  // Nothing follows the last entry of a dump.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result beat after last entry");

  // The first beat of a dump is rank one.
  a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##2 (out_valid && (out_rank == slr_pkg::RANK_W'(1))))
    else $error("dump did not start at rank one");

endmodule

bind sorted_leaderboard_update slr_checker u_slr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rank  (out_ch.rank),
  .out_last  (out_ch.last_entry)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted leaderboard update
// Drives name/score updates into the leaderboard and checks every ranked row
// it dumps against a scoreboard that keeps its own copy of the standings.
// Covers same-name replace, name terminators, ties, a full table and random
// traffic with backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAPACITY      = 16;
  localparam int POOL_SIZE     = 22;
  localparam int RANDOM_ITEMS  = 460;
  localparam int TAIL_ITEMS    = 60;   // final stretch runs with no idling
  localparam int PAUSE_AT      = 230;  // sender drains the block here
  localparam int LONG_HOLD     = 300;  // receiver stall that backs up the input
  localparam int HOLD_AFTER    = 2000; // rows seen before that stall
  localparam int RUN_LIMIT     = 600000;

  // Byte k at bits 8k+7:8k.
  typedef logic [slr_pkg::NAME_HI_W+slr_pkg::NAME_LO_W-1:0] name_bits_t;

  // One dumped row of the standings.
  typedef struct packed {
    logic [slr_pkg::RANK_W-1:0] rank;
    slr_pkg::slr_entry_t        entry;
    logic                       last;
  } ranked_row_t;

  // Holds the predicted standings and the rows the block still owes.
  class standings_tracker;
    slr_pkg::slr_entry_t standings[$];
    ranked_row_t         expected_rows[$];
    int                  capacity;
    int                  errors;

    function new(int cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // Apply one accepted update and queue the full dump it causes.
    function void apply_update(logic [slr_pkg::NAME_LO_W-1:0] name_lo,
                               logic [slr_pkg::NAME_HI_W-1:0] name_hi,
                               logic signed [slr_pkg::SCORE_W-1:0] score);
      slr_pkg::slr_entry_t fresh;
      ranked_row_t         row;
      bit                  ended;
      int                  hit;
      int                  slot;
      // Clear everything after the first zero character.
      ended = 0;
      for (int b = 0; b < 8; b++) begin
        if (ended) name_lo[8*b +: 8] = '0;
        else if (name_lo[8*b +: 8] == '0) ended = 1;
      end
      if (ended) name_hi = '0;
      fresh = '{name_lo: name_lo, name_hi: name_hi, score: score};

      hit = -1;
      foreach (standings[i])
        if (hit < 0 && standings[i].name_lo == name_lo && standings[i].name_hi == name_hi)
          hit = i;
      if (hit >= 0) standings.delete(hit);

      // New entry goes in front of the first strictly lower score.
      slot = standings.size();
      foreach (standings[i])
        if (slot == standings.size() && $signed(standings[i].score) < score) slot = i;

      if (standings.size() >= capacity) begin
        if (slot < standings.size()) standings.delete(standings.size() - 1);
        else slot = -1;
      end
      if (slot >= 0) standings.insert(slot, fresh);

      foreach (standings[i]) begin
        row.rank  = slr_pkg::RANK_W'(i + 1);
        row.entry = standings[i];
        row.last  = (i == standings.size() - 1);
        expected_rows.push_back(row);
      end
    endfunction

    function void check_row(ranked_row_t got);
      ranked_row_t want;
      if (expected_rows.size() == 0) begin
        $error("row with nothing expected: rank %0d score %0d",
               got.rank, $signed(got.entry.score));
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, got %0d", want.rank, got.rank);
        errors++;
      end
      if (got.entry.name_lo !== want.entry.name_lo) begin
        $error("entry_name_low: expected %h, got %h", want.entry.name_lo, got.entry.name_lo);
        errors++;
      end
      if (got.entry.name_hi !== want.entry.name_hi) begin
        $error("entry_name_high: expected %h, got %h", want.entry.name_hi, got.entry.name_hi);
        errors++;
      end
      if (got.entry.score !== want.entry.score) begin
        $error("entry_score: expected %0d, got %0d",
               $signed(want.entry.score), $signed(got.entry.score));
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_entry: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  slr_in_if  update_ch();
  slr_out_if standings_ch();

  standings_tracker board = new(CAPACITY);

  int cycle_count = 0;
  int rows_seen   = 0;
  bit quiet_tail  = 0;  // set by the sender once the no-idle tail starts

  sorted_leaderboard_update #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (update_ch),
    .out_ch(standings_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every row beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && standings_ch.valid && standings_ch.ready) begin
      board.check_row('{rank: standings_ch.rank,
                        entry: '{name_lo: standings_ch.entry_name_low,
                                 name_hi: standings_ch.entry_name_high,
                                 score: standings_ch.entry_score},
                        last: standings_ch.last_entry});
      rows_seen++;
    end
  end

  // Random name of 0 to 9 characters, clean after the terminator.
  function automatic name_bits_t random_name();
    name_bits_t nm;
    int len;
    nm  = '0;
    len = $urandom_range(0, 9);
    for (int k = 0; k < len; k++) nm[8*k +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // Fill the characters past the terminator with junk half of the time.
  function automatic name_bits_t add_junk(name_bits_t nm);
    int term;
    term = 9;
    for (int k = 0; k < 9; k++)
      if (term == 9 && nm[8*k +: 8] == '0) term = k;
    if ($urandom_range(0, 1) == 1)
      for (int k = term + 1; k < 9; k++) nm[8*k +: 8] = 8'($urandom());
    return nm;
  endfunction

  // Often a few tie-prone values, some extremes, the rest anywhere.
  function automatic logic signed [slr_pkg::SCORE_W-1:0] random_score();
    int pick;
    int step;
    pick = $urandom_range(0, 9);
    step = $urandom_range(0, 4);
    case (pick)
      0, 1, 2, 3: return slr_pkg::SCORE_W'((step - 2) * 65536);
      4:          return 32'sh8000_0000;
      5:          return 32'sh7FFF_FFFF;
      default:    return slr_pkg::SCORE_W'($urandom());
    endcase
  endfunction

  // Offer one update and hold it until the block takes the beat. Idle
  // afterwards only when asked, so valid never drops and rises in one step.
  task automatic offer_update(name_bits_t nm, logic signed [slr_pkg::SCORE_W-1:0] score,
                              bit may_idle);
    update_ch.valid     <= 1'b1;
    update_ch.name_low  <= nm[0 +: slr_pkg::NAME_LO_W];
    update_ch.name_high <= nm[slr_pkg::NAME_LO_W +: slr_pkg::NAME_HI_W];
    update_ch.score_in  <= score;
    do @(posedge clk); while (!update_ch.ready);
    board.apply_update(nm[0 +: slr_pkg::NAME_LO_W],
                       nm[slr_pkg::NAME_LO_W +: slr_pkg::NAME_HI_W], score);
    if (may_idle && $urandom_range(0, 2) == 0) begin
      update_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Directed opening: extremes, terminators, replace, ties, full table.
  task automatic run_directed();
    name_bits_t nm;
    // Nine 0xFF characters at the top score, then an empty name (junk
    // after the leading zero) at the bottom score.
    offer_update(72'hFF_FFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1);
    offer_update(72'hA5_0000_0000_0000_0000, 32'sh8000_0000, 1);
    // "A" with junk past its terminator, then clean "A" replacing it.
    offer_update(72'h12_3456_789A_BCDE_0041, 32'sh0000_0000, 1);
    offer_update(72'h00_0000_0000_0000_0041, 32'sh0005_0000, 1);
    // Eight high-bit characters, then nine characters; both tie at zero.
    offer_update(72'h00_8081_8283_8485_8687, 32'sh0000_0000, 1);
    offer_update(72'h7E_4142_4344_4546_4748, 32'sh0000_0000, 1);
    // Fill the table with two-character names on tie-heavy scores.
    for (int k = 0; k < 11; k++) begin
      nm = {56'h0, 8'(k + 1), 8'h51};
      offer_update(nm, slr_pkg::SCORE_W'(((k % 3) - 1) * 65536), 1);
    end
    // Table full: a new name tying the bottom ranks last and is discarded.
    offer_update(72'h00_0000_0000_0000_005A, 32'sh8000_0000, 1);
    // A new name in the middle pushes the bottom entry out.
    offer_update(72'h00_0000_0000_0000_005B, 32'sh0001_0000, 1);
    // Replace names while full.
    offer_update(72'h00_0000_0000_0000_0041, 32'sh8000_0000, 1);
    offer_update(72'hFF_FFFF_FFFF_FFFF_FFFF, 32'shFFFF_FFFF, 1);
  endtask

  // Sender: reset, directed opening, then random updates over a roster of
  // names larger than the table so that drops and replaces keep happening.
  initial begin
    name_bits_t roster[POOL_SIZE];
    name_bits_t nm;
    bit         in_tail;
    rst_n               <= 1'b0;
    update_ch.valid     <= 1'b0;
    update_ch.name_low  <= '0;
    update_ch.name_high <= '0;
    update_ch.score_in  <= '0;
    foreach (roster[i]) roster[i] = random_name();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      in_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      if (in_tail) quiet_tail = 1;
      if (n == PAUSE_AT) begin
        // Drain: hold off until every owed row has come out.
        update_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) nm = random_name();
      else nm = roster[$urandom_range(0, POOL_SIZE - 1)];
      offer_update(add_junk(nm), random_score(), !(in_tail || n == PAUSE_AT - 1));
    end
    update_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Receiver: random ready bursts, one long stall once traffic is flowing,
  // and ready held high through the tail.
  initial begin
    bit long_hold_done;
    long_hold_done = 0;
    standings_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        standings_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!long_hold_done && rows_seen >= HOLD_AFTER) begin
        // Hold off long enough for the block to back up its input.
        standings_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        standings_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        standings_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

endmodule

>>> files.f
sv/slr_pkg.sv
sv/slr_in_if.sv
sv/slr_out_if.sv
sv/slr_cell.sv
sv/sorted_leaderboard_update.sv
sv/slr_checker.sv
test/testbench.sv
